/* rtl/tfrs_pkg.sv */
// Shared types and constants for the thermometer frame record store.
// No dependencies; imported by tfrs_rec_mem, the top level, the checker and the testbench.
package tfrs_pkg;

	// default record capacity
	localparam int RECORDS_DEF = 128;

	// item kinds carried by op
	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// meter command codes in frame byte 1
	localparam logic [7:0] CMD_COUNT = 8'h2B;
	localparam logic [7:0] CMD_INFO  = 8'h25;
	localparam logic [7:0] CMD_TEMP  = 8'h26;
	localparam logic [7:0] CMD_CLEAR = 8'h52;

	// status codes
	localparam logic [2:0] ST_WAIT    = 3'd0;
	localparam logic [2:0] ST_COUNT   = 3'd1;
	localparam logic [2:0] ST_INFO    = 3'd2;
	localparam logic [2:0] ST_TEMP    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	// record field selectors
	localparam logic [3:0] FS_TYPE   = 4'd0;
	localparam logic [3:0] FS_UNIT   = 4'd1;
	localparam logic [3:0] FS_YEAR   = 4'd2;
	localparam logic [3:0] FS_MONTH  = 4'd3;
	localparam logic [3:0] FS_DAY    = 4'd4;
	localparam logic [3:0] FS_HOUR   = 4'd5;
	localparam logic [3:0] FS_MINUTE = 4'd6;
	localparam logic [3:0] FS_OBJ    = 4'd7;
	localparam logic [3:0] FS_BG     = 4'd8;

	// date and time half of a record
	typedef struct packed {
		logic [2:0] rec_type;
		logic       meas_unit;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
	} info_t;

	// temperature half of a record
	typedef struct packed {
		logic [15:0] obj_temp;
		logic [15:0] bg_temp;
	} temp_t;

	// write and read strobes toward the record memory
	typedef struct packed {
		logic info_we;
		logic temp_we;
		logic rd_en;
	} mem_ctl_t;

endpackage

/* rtl/thermometer_frame_record_store_unit.sv */
// Thermometer frame record store: top level with input stage, frame checks,
// dispatch and result register. Uses tfrs_pkg and tfrs_rec_mem.
//
// One item is taken per clock while results are taken. An item is held in the
// input register, where the checksum, command dispatch and record memory access
// happen. Its result is then held in the result register and shows on the
// outputs in the cycle after it leaves the input register.
// The rate is one item per cycle as long as results are taken; the record
// memory's single write and single read port serve one item each cycle.
// After reset the record memory is swept to zero entry by entry, and in_ready
// stays low during the sweep. Info and temperature writes go to the slot at
// write_index; once that index reaches RECORDS further writes are dropped.
module thermometer_frame_record_store_unit
	import tfrs_pkg::*;
#(
	parameter int RECORDS = RECORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  frame_byte_0,
	input  logic [7:0]  frame_byte_1,
	input  logic [7:0]  frame_byte_2,
	input  logic [7:0]  frame_byte_3,
	input  logic [7:0]  frame_byte_4,
	input  logic [7:0]  frame_byte_5,
	input  logic [7:0]  frame_byte_6,
	input  logic [7:0]  frame_byte_7,
	input  logic [6:0]  rec_index,
	input  logic [3:0]  field_sel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [2:0]  status,
	output logic [15:0] record_count,
	output logic [7:0]  write_index,
	output logic [15:0] read_value
);

	localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int SW = $clog2(RECORDS + 1);

	// input stage
	logic          v_s1;
	logic [1:0]    op_s1;
	logic [7:0]    fb_s1 [8];
	logic [6:0]    rec_index_s1;
	logic [3:0]    field_sel_s1;

	// block state and result register
	logic [15:0]   count_q;
	logic [2:0]    status_q;
	logic [SW-1:0] slot_q;
	logic          ok_q;
	logic          out_valid_q;
	logic [3:0]    fsel_q;
	logic          rhit_q;

	// combinational next values
	logic          adv;
	logic          mem_busy;
	logic [7:0]    sum;
	logic          chk_ok;
	logic          full;
	logic          frame_good;
	logic          ok_d;
	logic [2:0]    status_d;
	logic [15:0]   count_d;
	logic [SW-1:0] slot_d;
	logic          rhit_d;
	mem_ctl_t      mem_ctl;
	info_t         wr_info;
	temp_t         wr_temp;
	info_t         rd_info;
	temp_t         rd_temp;

	// handshake: stage advances when the result register is free
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !mem_busy && (!v_s1 || adv);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1        <= op;
			fb_s1[0]     <= frame_byte_0;
			fb_s1[1]     <= frame_byte_1;
			fb_s1[2]     <= frame_byte_2;
			fb_s1[3]     <= frame_byte_3;
			fb_s1[4]     <= frame_byte_4;
			fb_s1[5]     <= frame_byte_5;
			fb_s1[6]     <= frame_byte_6;
			fb_s1[7]     <= frame_byte_7;
			rec_index_s1 <= rec_index;
			field_sel_s1 <= field_sel;
		end
	end

	// checksum over bytes 0 to 6, modulo 256
	always_comb begin
		sum = fb_s1[0];
		for (int i = 1; i < 7; i++) begin
			sum = sum + fb_s1[i];
		end
	end

	assign chk_ok     = (sum == fb_s1[7]);
	assign full       = (slot_q == SW'(RECORDS));
	assign frame_good = (op_s1 == OP_FRAME) && chk_ok;

	// payload unpacking for record writes
	always_comb begin
		wr_info.rec_type  = {fb_s1[5][5], fb_s1[4][7:6]};
		wr_info.meas_unit = fb_s1[5][7];
		wr_info.year      = fb_s1[3][7:1];
		wr_info.month     = {fb_s1[3][0], fb_s1[2][7:5]};
		wr_info.day       = fb_s1[2][4:0];
		wr_info.hour      = fb_s1[5][4:0];
		wr_info.minute    = fb_s1[4][5:0];
		wr_temp.obj_temp  = {fb_s1[3], fb_s1[2]};
		wr_temp.bg_temp   = {fb_s1[5], fb_s1[4]};
	end

	// item dispatch and next state
	always_comb begin
		ok_d     = 1'b1;
		status_d = status_q;
		count_d  = count_q;
		slot_d   = slot_q;
		rhit_d   = 1'b0;
		mem_ctl  = '0;
		unique case (op_s1)
			OP_FRAME: begin
				ok_d = chk_ok;
				if (frame_good) begin
					unique case (fb_s1[1])
						CMD_COUNT: begin
							slot_d   = '0;
							count_d  = {fb_s1[3], fb_s1[2]};
							status_d = ST_COUNT;
						end
						CMD_INFO: begin
							mem_ctl.info_we = !full;
							status_d        = ST_INFO;
						end
						CMD_TEMP: begin
							mem_ctl.temp_we = !full;
							if (!full) begin
								slot_d = slot_q + 1'b1;
							end
							status_d = ST_TEMP;
						end
						CMD_CLEAR: begin
							status_d = ST_CLEARED;
						end
						default: begin
						end
					endcase
				end
			end
			OP_READ: begin
				mem_ctl.rd_en = 1'b1;
				rhit_d        = (32'(rec_index_s1) < RECORDS);
			end
			OP_CLEAR: begin
				status_d = ST_WAIT;
			end
			default: begin
			end
		endcase
		if (!adv) begin
			mem_ctl = '0;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			status_q    <= ST_WAIT;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				count_q  <= count_d;
				status_q <= status_d;
				slot_q   <= slot_d;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q   <= ok_d;
			fsel_q <= field_sel_s1;
			rhit_q <= rhit_d;
		end
	end

	// record memory
	tfrs_rec_mem #(
		.RECORDS(RECORDS)
	) u_rec_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_addr (AW'(slot_q)),
		.wr_info (wr_info),
		.wr_temp (wr_temp),
		.rd_addr (AW'(rec_index_s1)),
		.rd_info (rd_info),
		.rd_temp (rd_temp),
		.busy    (mem_busy)
	);

	// field select on the registered record
	always_comb begin
		unique case (fsel_q)
			FS_TYPE:   read_value = 16'(rd_info.rec_type);
			FS_UNIT:   read_value = 16'(rd_info.meas_unit);
			FS_YEAR:   read_value = 16'(rd_info.year);
			FS_MONTH:  read_value = 16'(rd_info.month);
			FS_DAY:    read_value = 16'(rd_info.day);
			FS_HOUR:   read_value = 16'(rd_info.hour);
			FS_MINUTE: read_value = 16'(rd_info.minute);
			FS_OBJ:    read_value = rd_temp.obj_temp;
			FS_BG:     read_value = rd_temp.bg_temp;
			default:   read_value = '0;
		endcase
		if (!rhit_q) begin
			read_value = '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign status       = status_q;
	assign record_count = count_q;
	assign write_index  = 8'(slot_q);

	// write index never passes capacity
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SW'(RECORDS))
		else $error("write index beyond capacity");

	// a frame with a bad checksum leaves all state alone
	a_bad_frame: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (op_s1 == OP_FRAME) && !chk_ok |=>
		!ok_q && $stable(slot_q) && $stable(status_q) && $stable(count_q))
		else $error("bad checksum frame changed state");

	// a stored temperature record advances the index by one
	a_temp_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv && frame_good && (fb_s1[1] == CMD_TEMP) && !full |=>
		slot_q == $past(slot_q) + 1'b1)
		else $error("temperature record did not advance index");

	// no item in flight while the memory is being cleared
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !v_s1)
		else $error("item taken during memory clear");

endmodule

/* rtl/tfrs_rec_mem.sv */
// Record memory: separate info and temperature arrays, one write port,
// one registered read port, zero-fill sweep after reset. Uses tfrs_pkg.
module tfrs_rec_mem
	import tfrs_pkg::*;
#(
	parameter int RECORDS = RECORDS_DEF,
	localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] wr_addr,
	input  info_t         wr_info,
	input  temp_t         wr_temp,
	input  logic [AW-1:0] rd_addr,
	output info_t         rd_info,
	output temp_t         rd_temp,
	output logic          busy
);

	info_t         info_mem [RECORDS];
	temp_t         temp_mem [RECORDS];
	logic          busy_q;
	logic [AW-1:0] clr_q;
	info_t         rd_info_q;
	temp_t         rd_temp_q;

	// clearing sweep, one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(RECORDS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// write port, shared by the sweep and record writes
	always_ff @(posedge clk) begin
		if (busy_q) begin
			info_mem[clr_q] <= '0;
			temp_mem[clr_q] <= '0;
		end else begin
			if (ctl.info_we) begin
				info_mem[wr_addr] <= wr_info;
			end
			if (ctl.temp_we) begin
				temp_mem[wr_addr] <= wr_temp;
			end
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_info_q <= info_mem[rd_addr];
			rd_temp_q <= temp_mem[rd_addr];
		end
	end

	assign rd_info = rd_info_q;
	assign rd_temp = rd_temp_q;
	assign busy    = busy_q;

endmodule

/* test/thermometer_frame_record_store_check.sv */
// Checker for the thermometer frame record store: watches both channels, predicts each result.
// Depends on tfrs_pkg for the op, command, status and field codes and the record layouts.
module thermometer_frame_record_store_check
	import tfrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  frame_byte_0,
	input  logic [7:0]  frame_byte_1,
	input  logic [7:0]  frame_byte_2,
	input  logic [7:0]  frame_byte_3,
	input  logic [7:0]  frame_byte_4,
	input  logic [7:0]  frame_byte_5,
	input  logic [7:0]  frame_byte_6,
	input  logic [7:0]  frame_byte_7,
	input  logic [6:0]  rec_index,
	input  logic [3:0]  field_sel,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        ok,
	input  logic [2:0]  status,
	input  logic [15:0] record_count,
	input  logic [7:0]  write_index,
	input  logic [15:0] read_value,
	output int          results_pending,
	output int          fail_count
);

	// one predicted result
	typedef struct {
		logic        ok;
		logic [2:0]  status;
		logic [15:0] count;
		logic [7:0]  windex;
		logic [15:0] rval;
	} meter_result_t;

	// predicted state of the block
	logic [15:0] count_q;
	logic [2:0]  status_q;
	int          slot_q;
	info_t       info_mem [RECORDS_DEF];
	temp_t       temp_mem [RECORDS_DEF];

	meter_result_t expected_results [$];

	initial fail_count = 0;

	// apply one item to the predicted state and return its result
	function automatic meter_result_t apply_item(input logic [1:0] kind, input logic [63:0] fr,
			input logic [6:0] idx, input logic [3:0] sel);
		meter_result_t r;
		logic [7:0]    b [8];
		logic [7:0]    sum;
		logic [15:0]   date;
		info_t         ri;
		temp_t         rt;
		int            i;
		for (i = 0; i < 8; i++) b[i] = fr[8*i +: 8];
		r.ok = 1'b1;
		r.rval = 16'd0;
		case (kind)
			OP_FRAME: begin
				sum = 8'd0;
				for (i = 0; i < 7; i++) sum += b[i];
				if (sum != b[7]) begin
					r.ok = 1'b0;
				end else begin
					case (b[1])
						CMD_COUNT: begin
							slot_q = 0;
							count_q = {b[3], b[2]};
							status_q = ST_COUNT;
						end
						CMD_INFO: begin
							// date and time land in the current slot unless the store is full
							if (slot_q < RECORDS_DEF) begin
								date = {b[3], b[2]};
								info_mem[slot_q].year = date[15:9];
								info_mem[slot_q].month = date[8:5];
								info_mem[slot_q].day = date[4:0];
								info_mem[slot_q].hour = b[5][4:0];
								info_mem[slot_q].minute = b[4][5:0];
								info_mem[slot_q].meas_unit = b[5][7];
								info_mem[slot_q].rec_type = {b[5][5], b[4][7:6]};
							end
							status_q = ST_INFO;
						end
						CMD_TEMP: begin
							if (slot_q < RECORDS_DEF) begin
								temp_mem[slot_q].obj_temp = {b[3], b[2]};
								temp_mem[slot_q].bg_temp = {b[5], b[4]};
								slot_q++;
							end
							status_q = ST_TEMP;
						end
						CMD_CLEAR: begin
							status_q = ST_CLEARED;
						end
						default: begin
						end
					endcase
				end
			end
			OP_READ: begin
				if (idx < RECORDS_DEF) begin
					ri = info_mem[idx];
					rt = temp_mem[idx];
					case (sel)
						FS_TYPE:   r.rval = 16'(ri.rec_type);
						FS_UNIT:   r.rval = 16'(ri.meas_unit);
						FS_YEAR:   r.rval = 16'(ri.year);
						FS_MONTH:  r.rval = 16'(ri.month);
						FS_DAY:    r.rval = 16'(ri.day);
						FS_HOUR:   r.rval = 16'(ri.hour);
						FS_MINUTE: r.rval = 16'(ri.minute);
						FS_OBJ:    r.rval = rt.obj_temp;
						FS_BG:     r.rval = rt.bg_temp;
						default:   r.rval = 16'd0;
					endcase
				end
			end
			OP_CLEAR: begin
				status_q = ST_WAIT;
			end
			default: begin
				// unused op: nothing changes
			end
		endcase
		r.status = status_q;
		r.count = count_q;
		r.windex = slot_q[7:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// result transfers are compared first, then the input transfer is predicted
	always @(posedge clk or negedge arst_n) begin
		meter_result_t got;
		meter_result_t want;
		if (!arst_n) begin
			count_q = 16'd0;
			status_q = ST_WAIT;
			slot_q = 0;
			for (int i = 0; i < RECORDS_DEF; i++) begin
				info_mem[i] = '0;
				temp_mem[i] = '0;
			end
			expected_results.delete();
			results_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no prediction waiting");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("ok", 16'(want.ok), 16'(ok));
					check_field("status", 16'(want.status), 16'(status));
					check_field("record_count", want.count, record_count);
					check_field("write_index", 16'(want.windex), 16'(write_index));
					check_field("read_value", want.rval, read_value);
				end
			end
			if (in_valid && in_ready) begin
				got = apply_item(op, {frame_byte_7, frame_byte_6, frame_byte_5, frame_byte_4,
					frame_byte_3, frame_byte_2, frame_byte_1, frame_byte_0},
					rec_index, field_sel);
				expected_results.push_back(got);
			end
			results_pending = expected_results.size();
		end
	end

endmodule

/* test/thermometer_frame_record_store_unit_test.sv */
// Testbench top for the thermometer frame record store: clock, reset, stimulus and verdict.
// Depends on tfrs_pkg, the block itself and thermometer_frame_record_store_check.
module thermometer_frame_record_store_unit_test;
	import tfrs_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 900;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3;
	logic [7:0]  frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7;
	logic [6:0]  rec_index;
	logic [3:0]  field_sel;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic [2:0]  status;
	logic [15:0] record_count;
	logic [7:0]  write_index;
	logic [15:0] read_value;

	int results_pending;
	int check_failures;
	int items_sent;
	bit calm;

	thermometer_frame_record_store_unit DUT (.*);

	thermometer_frame_record_store_check checker_i (
		.clk, .arst_n, .in_valid, .in_ready, .op,
		.frame_byte_0, .frame_byte_1, .frame_byte_2, .frame_byte_3,
		.frame_byte_4, .frame_byte_5, .frame_byte_6, .frame_byte_7,
		.rec_index, .field_sel, .out_valid, .out_ready, .ok, .status,
		.record_count, .write_index, .read_value,
		.results_pending, .fail_count(check_failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long; none at all in calm stretches
	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// frame with random header and trailer and a correct checksum
	function automatic logic [63:0] frame_with_sum(input logic [7:0] cmd,
			input logic [31:0] payload);
		logic [63:0] fr;
		logic [7:0]  sum;
		fr[7:0] = 8'($urandom);
		fr[15:8] = cmd;
		fr[47:16] = payload;
		fr[55:48] = 8'($urandom);
		sum = 8'd0;
		for (int i = 0; i < 7; i++) sum += fr[8*i +: 8];
		fr[63:56] = sum;
		return fr;
	endfunction

	function automatic logic [7:0] other_cmd();
		logic [7:0] c;
		do c = 8'($urandom);
		while (c == CMD_COUNT || c == CMD_INFO || c == CMD_TEMP || c == CMD_CLEAR);
		return c;
	endfunction

	// one input transfer, then a random gap
	task automatic put_item(input logic [1:0] kind, input logic [63:0] fr,
			input logic [6:0] idx, input logic [3:0] sel);
		int gap;
		in_valid <= 1'b1;
		op <= kind;
		frame_byte_0 <= fr[7:0];
		frame_byte_1 <= fr[15:8];
		frame_byte_2 <= fr[23:16];
		frame_byte_3 <= fr[31:24];
		frame_byte_4 <= fr[39:32];
		frame_byte_5 <= fr[47:40];
		frame_byte_6 <= fr[55:48];
		frame_byte_7 <= fr[63:56];
		rec_index <= idx;
		field_sel <= sel;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] cmd, input logic [31:0] payload);
		put_item(OP_FRAME, frame_with_sum(cmd, payload), 7'($urandom), 4'($urandom));
	endtask

	task automatic send_read(input logic [6:0] idx, input logic [3:0] sel);
		put_item(OP_READ, {$urandom, $urandom}, idx, sel);
	endtask

	task automatic send_bad_frame(input logic [7:0] cmd, input logic [31:0] payload);
		logic [63:0] fr;
		fr = frame_with_sum(cmd, payload);
		fr[63:56] ^= 8'($urandom_range(1, 255));
		put_item(OP_FRAME, fr, 7'($urandom), 4'($urandom));
	endtask

	// odd items mixed into the record sequences
	task automatic noise_item();
		logic [7:0] known [4];
		known = '{CMD_COUNT, CMD_INFO, CMD_TEMP, CMD_CLEAR};
		case ($urandom_range(0, 6))
			0: send_bad_frame(known[$urandom_range(0, 3)], $urandom);
			1: send_frame(other_cmd(), $urandom);
			2: send_frame(CMD_CLEAR, $urandom);
			3: put_item(OP_CLEAR, {$urandom, $urandom}, 7'($urandom), 4'($urandom));
			4: put_item(OP_UNUSED, {$urandom, $urandom}, 7'($urandom), 4'($urandom));
			5: put_item(OP_FRAME, {$urandom, $urandom}, 7'($urandom), 4'($urandom));
			default: send_read(7'($urandom), 4'($urandom));
		endcase
	endtask

	// result side: runs of ready and stall
	initial begin
		int run_left;
		out_ready = 1'b0;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				out_ready <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else if ($urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				run_left = $urandom_range(0, 8);
			end else begin
				out_ready <= 1'b0;
				run_left = idle_len();
			end
		end
	end

	// stimulus
	initial begin
		bit full;
		bit first;
		int n;
		int last_slot;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_FRAME;
		{frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3} = '0;
		{frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7} = '0;
		rec_index = '0;
		field_sel = '0;
		calm = 1'b0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: cleared store, field extremes, every command and item kind
		send_read(7'd0, FS_TYPE);
		send_read(7'd127, FS_BG);
		send_frame(CMD_COUNT, 32'h0000_FFFF);
		send_frame(CMD_INFO, 32'hFFFF_FFFF);
		send_frame(CMD_TEMP, 32'hFFFF_FFFF);
		send_frame(CMD_INFO, 32'h0000_0000);
		send_frame(CMD_TEMP, 32'h0000_0000);
		for (int s = 0; s <= 9; s++) send_read(7'd0, 4'(s));
		send_read(7'd1, 4'hF);
		send_bad_frame(CMD_COUNT, 32'h0000_0000);
		send_frame(CMD_CLEAR, $urandom);
		send_frame(other_cmd(), $urandom);
		put_item(OP_UNUSED, {$urandom, $urandom}, 7'($urandom), 4'($urandom));
		put_item(OP_CLEAR, {$urandom, $urandom}, 7'($urandom), 4'($urandom));
		send_frame(CMD_COUNT, 32'h0000_0000);

		// random: count, then info and temperature pairs (in full runs info is mostly left out), then reads back
		first = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			full = first || ($urandom_range(0, 19) == 0);
			first = 1'b0;
			calm = ($urandom_range(0, 5) == 0);
			n = full ? RECORDS_DEF + 4 : $urandom_range(0, 12);
			send_frame(CMD_COUNT, {16'($urandom), 16'($urandom)});
			for (int i = 0; i < n; i++) begin
				if (!full || i >= RECORDS_DEF || $urandom_range(0, 3) == 0)
					send_frame(CMD_INFO, $urandom);
				send_frame(CMD_TEMP, $urandom);
				if ($urandom_range(0, 4) == 0) noise_item();
			end
			last_slot = full ? RECORDS_DEF - 1 : ((n > 0) ? n - 1 : 0);
			repeat ($urandom_range(2, 8)) begin
				if ($urandom_range(0, 2) != 0)
					send_read(7'($urandom_range(0, last_slot)), 4'($urandom_range(0, 8)));
				else
					send_read(7'($urandom), 4'($urandom));
			end
			if ($urandom_range(0, 2) == 0) noise_item();
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// drain, then keep watching for anything stray
		while (results_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (check_failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
